### sv/ltrk_pkg.sv
// Shared types and constants of the loop nesting tracker.
package ltrk_pkg;

  localparam int unsigned LTRK_MAX_LOOPS = 64;
  localparam int unsigned LTRK_OFS_W     = 16;
  localparam int unsigned LTRK_LOOP_W    = LTRK_OFS_W + 1;
  localparam int unsigned LTRK_IDX_W     = (LTRK_MAX_LOOPS > 1) ? $clog2(LTRK_MAX_LOOPS) : 1;
  localparam int unsigned LTRK_CMD_W     = 3;
  localparam int unsigned LTRK_STAT_W    = 2;

  // packed stream words, padded to whole bytes
  localparam int unsigned LTRK_IN_RAW_W  = LTRK_CMD_W + 2 * LTRK_OFS_W;
  localparam int unsigned LTRK_IN_W      = ((LTRK_IN_RAW_W + 7) / 8) * 8;
  localparam int unsigned LTRK_OUT_RAW_W = LTRK_LOOP_W + LTRK_STAT_W;
  localparam int unsigned LTRK_OUT_W     = ((LTRK_OUT_RAW_W + 7) / 8) * 8;

  // "no loop"
  localparam logic [LTRK_LOOP_W-1:0] LTRK_LOOP_NONE = '1;

  typedef enum logic [LTRK_CMD_W-1:0] {
    CMD_HEADER       = 3'd0,
    CMD_JUMP         = 3'd1,
    CMD_QUERY_LOOP   = 3'd2,
    CMD_QUERY_PARENT = 3'd3,
    CMD_BEGIN        = 3'd4
  } cmd_e;

  typedef enum logic [LTRK_STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_HEADER = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic load;    // capture request, reset scan
    logic scan;    // read table entry at scan index
    logic commit;  // apply table writes, emit result
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
  } dp_status_t;

  typedef struct packed {
    logic [LTRK_OFS_W-1:0]  key;
    logic [LTRK_LOOP_W-1:0] parent;
  } hdr_ent_t;

  typedef struct packed {
    logic [LTRK_OFS_W-1:0] origin;
    logic [LTRK_OFS_W-1:0] header;
  } be_ent_t;

endpackage

### sv/loop_nesting_tracker_unit.sv
// Top level of the loop nesting tracker: stream ports, sequencer, datapath, output register.
//
//  channel   | dir | tdata fields (lowest bit first)                     | tuser/tlast
//  ----------+-----+------------------------------------------------------+------------
//  s_axis    | in  | command[2:0], offset[18:3], jump_target[34:19], pad  | none
//  m_axis    | out | loop_offset[16:0] (signed), status[18:17], pad       | none
//
//  Paths: begin, forward jumps and unused commands go from decode straight to
//  commit; header, backward jump and both queries first walk the table
//  memories one entry per cycle, over all LTRK_MAX_LOOPS (64) entries.
//  Reset clears the valid bits of both tables and sets the current loop to -1;
//  no clearing pass, the block takes a request right after reset.
//  Stalls: a result waits in the output register; the next request is taken
//  meanwhile and only its final commit waits for that register to drain.
module loop_nesting_tracker_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command[2:0], offset[18:3], jump_target[34:19], zero pad
  input  logic [ltrk_pkg::LTRK_IN_W-1:0]  s_axis_tdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // loop_offset[16:0], status[18:17], zero pad
  output logic [ltrk_pkg::LTRK_OUT_W-1:0] m_axis_tdata_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i
);
  import ltrk_pkg::*;

  ctrl_cmd_t              ctrl;
  dp_status_t             dp_stat;
  logic                   out_free;
  logic [LTRK_LOOP_W-1:0] res_loop;
  status_e                res_status;

  // output register
  logic                   out_v_q;
  logic [LTRK_LOOP_W-1:0] out_loop_q;
  status_e                out_stat_q;

  // result may land when the register is empty or being drained this cycle
  assign out_free = !out_v_q || m_axis_tready_i;

  ltrk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .out_free_i  (out_free),
    .stat_i      (dp_stat),
    .ctrl_o      (ctrl)
  );

  ltrk_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .cmd_i        (s_axis_tdata_i[LTRK_CMD_W-1:0]),
    .offset_i     (s_axis_tdata_i[LTRK_CMD_W +: LTRK_OFS_W]),
    .target_i     (s_axis_tdata_i[LTRK_CMD_W + LTRK_OFS_W +: LTRK_OFS_W]),
    .stat_o       (dp_stat),
    .res_loop_o   (res_loop),
    .res_status_o (res_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (ctrl.commit) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.commit) begin
      out_loop_q <= res_loop;
      out_stat_q <= res_status;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {{(LTRK_OUT_W - LTRK_OUT_RAW_W){1'b0}}, out_stat_q, out_loop_q};

  // a commit always leaves a result for the consumer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.commit |=> m_axis_tvalid_o)
    else $error("commit did not present a result");

  // never overwrite a result that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.commit |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result overwritten before it was taken");

  // one request at a time: ready drops after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("second request taken while one is in flight");

  // table walk only for requests that need it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ctrl.scan) |-> dp_stat.need_scan)
    else $error("table scan started for a request without lookup");

endmodule

### sv/ltrk_ctrl.sv
// Sequencer for the loop nesting tracker: accept, table scan, commit.
module ltrk_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  output logic                   req_ready_o,
  input  logic                   out_free_i,
  input  ltrk_pkg::dp_status_t   stat_i,
  output ltrk_pkg::ctrl_cmd_t    ctrl_o
);
  import ltrk_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = stat_i.need_scan ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        ctrl_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FINISH;  // last read entry folds in
      end
      S_FINISH: begin
        if (out_free_i) begin
          ctrl_o.commit = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### sv/ltrk_dpath.sv
// Datapath: header and backedge tables, scan accumulators, result logic.
module ltrk_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ltrk_pkg::ctrl_cmd_t                 ctrl_i,
  input  logic [ltrk_pkg::LTRK_CMD_W-1:0]     cmd_i,
  input  logic [ltrk_pkg::LTRK_OFS_W-1:0]     offset_i,
  input  logic [ltrk_pkg::LTRK_OFS_W-1:0]     target_i,
  output ltrk_pkg::dp_status_t                stat_o,
  output logic [ltrk_pkg::LTRK_LOOP_W-1:0]    res_loop_o,
  output ltrk_pkg::status_e                   res_status_o
);
  import ltrk_pkg::*;

  // request
  cmd_e                   cmd_q;
  logic [LTRK_OFS_W-1:0]  ofs_q, tgt_q;
  logic [LTRK_LOOP_W-1:0] cur_q, cur_d;

  // tables
  hdr_ent_t               hdr_mem [LTRK_MAX_LOOPS];
  be_ent_t                be_mem  [LTRK_MAX_LOOPS];
  logic [LTRK_MAX_LOOPS-1:0] hvalid_q, bvalid_q;
  hdr_ent_t               hdr_rd_q;
  be_ent_t                be_rd_q;

  // scan
  logic [LTRK_IDX_W-1:0]  scan_idx_q, rd_idx_q;
  logic                   rd_v_q;

  // accumulators
  logic                   hm_q, hf_q, bm_q, bf_q, bc_q, hc_q;
  logic [LTRK_IDX_W-1:0]  hm_idx_q, hf_idx_q, bm_idx_q, bf_idx_q;
  logic [LTRK_LOOP_W-1:0] hm_par_q, hc_par_q;
  logic [LTRK_OFS_W-1:0]  bc_org_q, bc_hdr_q, hc_key_q;

  // finish
  logic                   h_we, b_we, clr;
  logic [LTRK_IDX_W-1:0]  h_waddr, b_waddr;
  hdr_ent_t               h_wdata;
  be_ent_t                b_wdata;
  logic [LTRK_LOOP_W-1:0] ans;
  status_e                st;

  logic [LTRK_OFS_W-1:0]  hkey;
  logic                   hv, bv;
  logic                   hit_hm, hit_hf, hit_bm, hit_bf, hit_bc, hit_hc;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= cmd_e'(cmd_i);
      ofs_q <= offset_i;
      tgt_q <= target_i;
    end
  end

  assign stat_o.need_scan = (cmd_q == CMD_HEADER) || (cmd_q == CMD_QUERY_LOOP) ||
                            (cmd_q == CMD_QUERY_PARENT) ||
                            ((cmd_q == CMD_JUMP) && (tgt_q < ofs_q));
  assign stat_o.scan_last = (scan_idx_q == LTRK_IDX_W'(LTRK_MAX_LOOPS - 1));

  // memories: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit && h_we) begin
      hdr_mem[h_waddr] <= h_wdata;
    end
    hdr_rd_q <= hdr_mem[scan_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit && b_we) begin
      be_mem[b_waddr] <= b_wdata;
    end
    be_rd_q <= be_mem[scan_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvalid_q <= '0;
      bvalid_q <= '0;
      cur_q    <= LTRK_LOOP_NONE;
    end else if (ctrl_i.commit) begin
      cur_q <= cur_d;
      if (clr) begin
        hvalid_q <= '0;
        bvalid_q <= '0;
      end else begin
        if (h_we) hvalid_q[h_waddr] <= 1'b1;
        if (b_we) bvalid_q[b_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      rd_idx_q   <= '0;
      rd_v_q     <= 1'b0;
    end else begin
      rd_v_q   <= ctrl_i.scan;
      rd_idx_q <= scan_idx_q;
      if (ctrl_i.load) begin
        scan_idx_q <= '0;
      end else if (ctrl_i.scan) begin
        scan_idx_q <= scan_idx_q + LTRK_IDX_W'(1);
      end
    end
  end

  // per-entry compares on the registered read
  assign hkey   = (cmd_q == CMD_JUMP) ? tgt_q : ofs_q;
  assign hv     = hvalid_q[rd_idx_q];
  assign bv     = bvalid_q[rd_idx_q];
  assign hit_hm = rd_v_q && hv && (hdr_rd_q.key == hkey) && !hm_q;
  assign hit_hf = rd_v_q && !hv && !hf_q;
  assign hit_bm = rd_v_q && bv && (be_rd_q.origin == ofs_q) && !bm_q;
  assign hit_bf = rd_v_q && !bv && !bf_q;
  assign hit_bc = rd_v_q && bv && (be_rd_q.origin >= ofs_q) &&
                  (!bc_q || (be_rd_q.origin < bc_org_q));
  assign hit_hc = rd_v_q && hv && (hdr_rd_q.key > ofs_q) &&
                  (!hc_q || (hdr_rd_q.key < hc_key_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hm_q <= 1'b0;
      hf_q <= 1'b0;
      bm_q <= 1'b0;
      bf_q <= 1'b0;
      bc_q <= 1'b0;
      hc_q <= 1'b0;
    end else if (ctrl_i.load) begin
      hm_q <= 1'b0;
      hf_q <= 1'b0;
      bm_q <= 1'b0;
      bf_q <= 1'b0;
      bc_q <= 1'b0;
      hc_q <= 1'b0;
    end else begin
      if (hit_hm) hm_q <= 1'b1;
      if (hit_hf) hf_q <= 1'b1;
      if (hit_bm) bm_q <= 1'b1;
      if (hit_bf) bf_q <= 1'b1;
      if (hit_bc) bc_q <= 1'b1;
      if (hit_hc) hc_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit_hm) begin
      hm_idx_q <= rd_idx_q;
      hm_par_q <= hdr_rd_q.parent;
    end
    if (hit_hf) hf_idx_q <= rd_idx_q;
    if (hit_bm) bm_idx_q <= rd_idx_q;
    if (hit_bf) bf_idx_q <= rd_idx_q;
    if (hit_bc) begin
      bc_org_q <= be_rd_q.origin;
      bc_hdr_q <= be_rd_q.header;
    end
    if (hit_hc) begin
      hc_key_q <= hdr_rd_q.key;
      hc_par_q <= hdr_rd_q.parent;
    end
  end

  // result and table updates
  always_comb begin
    ans     = cur_q;
    st      = ST_OK;
    cur_d   = cur_q;
    clr     = 1'b0;
    h_we    = 1'b0;
    h_waddr = hm_q ? hm_idx_q : hf_idx_q;
    h_wdata = '{key: ofs_q, parent: cur_q};
    b_we    = 1'b0;
    b_waddr = bm_q ? bm_idx_q : bf_idx_q;
    b_wdata = '{origin: ofs_q, header: tgt_q};
    unique case (cmd_q)
      CMD_HEADER: begin
        if (hm_q || hf_q) begin
          h_we  = 1'b1;
          cur_d = {1'b0, ofs_q};
          ans   = {1'b0, ofs_q};
        end else begin
          st = ST_FULL;
        end
      end
      CMD_JUMP: begin
        if (tgt_q < ofs_q) begin
          if ((bm_q || bf_q) && (hm_q || hf_q)) begin
            b_we = 1'b1;
            if (!hm_q) begin
              // unknown header gets created with parent 0
              h_we    = 1'b1;
              h_wdata = '{key: tgt_q, parent: '0};
            end
            cur_d = hm_q ? hm_par_q : '0;
            ans   = hm_q ? hm_par_q : '0;
          end else begin
            st = ST_FULL;
          end
        end
      end
      CMD_QUERY_LOOP: begin
        if (!bc_q) begin
          ans = LTRK_LOOP_NONE;
        end else if (bc_hdr_q <= ofs_q) begin
          ans = {1'b0, bc_hdr_q};
        end else if (!hc_q) begin
          ans = LTRK_LOOP_NONE;
          st  = ST_NO_HEADER;
        end else begin
          ans = hc_par_q;
        end
      end
      CMD_QUERY_PARENT: begin
        if (hm_q) begin
          ans = hm_par_q;
        end else begin
          ans = LTRK_LOOP_NONE;
          st  = ST_NO_HEADER;
        end
      end
      CMD_BEGIN: begin
        clr   = 1'b1;
        cur_d = LTRK_LOOP_NONE;
        ans   = LTRK_LOOP_NONE;
      end
      default: begin
      end
    endcase
  end

  assign res_loop_o   = ans;
  assign res_status_o = st;

endmodule

### test/tb_loop_nesting_tracker_unit.sv
// Testbench of the loop nesting tracker: directed and random event streams checked against a predictor.
`timescale 1ns / 100ps

module tb_loop_nesting_tracker_unit;
  import ltrk_pkg::*;

  // one predicted result: loop answer and status
  typedef struct {
    logic [LTRK_LOOP_W-1:0] loop;
    status_e                stat;
  } loop_answer_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic [LTRK_IN_W-1:0]  s_axis_tdata_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [LTRK_OUT_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;

  loop_nesting_tracker_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

  // predictor state: current loop, header table, backedge table
  logic [LTRK_LOOP_W-1:0] cur_loop = LTRK_LOOP_NONE;
  logic [LTRK_OFS_W-1:0]  hdr_key [LTRK_MAX_LOOPS];
  logic [LTRK_LOOP_W-1:0] hdr_par [LTRK_MAX_LOOPS];
  bit                     hdr_vld [LTRK_MAX_LOOPS];
  logic [LTRK_OFS_W-1:0]  be_org  [LTRK_MAX_LOOPS];
  logic [LTRK_OFS_W-1:0]  be_hdr  [LTRK_MAX_LOOPS];
  bit                     be_vld  [LTRK_MAX_LOOPS];

  loop_answer_t pending_answers[$];
  int           fail_cnt    = 0;
  bit           tx_idle_on  = 1'b1;
  bit           rx_idle_on  = 1'b1;
  int           rx_hold_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("Verification failed");
    $finish;
  end

  function automatic int find_hdr(logic [LTRK_OFS_W-1:0] key);
    for (int i = 0; i < LTRK_MAX_LOOPS; i++)
      if (hdr_vld[i] && hdr_key[i] == key) return i;
    return -1;
  endfunction

  function automatic int free_hdr();
    for (int i = 0; i < LTRK_MAX_LOOPS; i++)
      if (!hdr_vld[i]) return i;
    return -1;
  endfunction

  // Applies one event to the predicted tables, returns the expected answer.
  function automatic loop_answer_t track_nesting(logic [LTRK_CMD_W-1:0] cmd,
                                                 logic [LTRK_OFS_W-1:0] ofs,
                                                 logic [LTRK_OFS_W-1:0] tgt);
    loop_answer_t r;
    int hi, hs, bi, bs;
    r.loop = cur_loop;
    r.stat = ST_OK;
    case (cmd)
      CMD_HEADER: begin
        hi = find_hdr(ofs);
        if (hi < 0) begin
          hi = free_hdr();
          if (hi >= 0) begin
            hdr_vld[hi] = 1'b1;
            hdr_key[hi] = ofs;
          end
        end
        if (hi < 0) begin
          r.stat = ST_FULL;
        end else begin
          hdr_par[hi] = cur_loop;
          cur_loop    = {1'b0, ofs};
          r.loop      = cur_loop;
        end
      end
      CMD_JUMP: begin
        if (tgt < ofs) begin
          bi = -1;
          bs = -1;
          for (int i = 0; i < LTRK_MAX_LOOPS; i++)
            if (bi < 0 && be_vld[i] && be_org[i] == ofs) bi = i;
          for (int i = 0; i < LTRK_MAX_LOOPS; i++)
            if (bs < 0 && !be_vld[i]) bs = i;
          if (bi >= 0) bs = bi;
          hi = find_hdr(tgt);
          hs = (hi < 0) ? free_hdr() : hi;
          if (bs < 0 || hs < 0) begin
            r.stat = ST_FULL;
          end else begin
            be_vld[bs] = 1'b1;
            be_org[bs] = ofs;
            be_hdr[bs] = tgt;
            // backedge to an unknown header creates it with parent 0
            if (hi < 0) begin
              hdr_vld[hs] = 1'b1;
              hdr_key[hs] = tgt;
              hdr_par[hs] = '0;
            end
            cur_loop = hdr_par[hs];
            r.loop   = cur_loop;
          end
        end
      end
      CMD_QUERY_LOOP: begin
        bi = -1;
        for (int i = 0; i < LTRK_MAX_LOOPS; i++)
          if (be_vld[i] && be_org[i] >= ofs && (bi < 0 || be_org[i] < be_org[bi])) bi = i;
        if (bi < 0) begin
          r.loop = LTRK_LOOP_NONE;
        end else if (be_hdr[bi] <= ofs) begin
          r.loop = {1'b0, be_hdr[bi]};
        end else begin
          hi = -1;
          for (int i = 0; i < LTRK_MAX_LOOPS; i++)
            if (hdr_vld[i] && hdr_key[i] > ofs && (hi < 0 || hdr_key[i] < hdr_key[hi])) hi = i;
          if (hi < 0) begin
            r.loop = LTRK_LOOP_NONE;
            r.stat = ST_NO_HEADER;
          end else begin
            r.loop = hdr_par[hi];
          end
        end
      end
      CMD_QUERY_PARENT: begin
        hi = find_hdr(ofs);
        if (hi < 0) begin
          r.loop = LTRK_LOOP_NONE;
          r.stat = ST_NO_HEADER;
        end else begin
          r.loop = hdr_par[hi];
        end
      end
      CMD_BEGIN: begin
        for (int i = 0; i < LTRK_MAX_LOOPS; i++) begin
          hdr_vld[i] = 1'b0;
          be_vld[i]  = 1'b0;
        end
        cur_loop = LTRK_LOOP_NONE;
        r.loop   = LTRK_LOOP_NONE;
      end
      default: ;  // unused codes leave everything alone
    endcase
    return r;
  endfunction

  // Offers one request, waits for it to be taken, then predicts its answer.
  task automatic send_req(logic [LTRK_CMD_W-1:0] cmd, logic [LTRK_OFS_W-1:0] ofs,
                          logic [LTRK_OFS_W-1:0] tgt);
    logic [LTRK_IN_W-1:0] word;
    if (tx_idle_on && $urandom_range(99) < 29) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 90)) @(posedge clk_i);
    end
    word        = '0;
    word[2:0]   = cmd;
    word[18:3]  = ofs;
    word[34:19] = tgt;
    s_axis_tdata_i  <= word;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_answers.push_back(track_nesting(cmd, ofs, tgt));
  endtask

  // Result side: checks each accepted result, drives tready with stalls.
  initial begin
    loop_answer_t exp_ans;
    logic [LTRK_LOOP_W-1:0] got_loop;
    logic [LTRK_STAT_W-1:0] got_stat;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        got_loop = m_axis_tdata_o[16:0];
        got_stat = m_axis_tdata_o[18:17];
        if (pending_answers.size() == 0) begin
          $error("unexpected result: loop_offset %0d, status %0d", $signed(got_loop), got_stat);
          fail_cnt++;
        end else begin
          exp_ans = pending_answers.pop_front();
          if (got_loop !== exp_ans.loop) begin
            $error("loop_offset mismatch: expected %0d, actual %0d",
                   $signed(exp_ans.loop), $signed(got_loop));
            fail_cnt++;
          end
          if (got_stat !== exp_ans.stat) begin
            $error("status mismatch: expected %0d, actual %0d", exp_ans.stat, got_stat);
            fail_cnt++;
          end
        end
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (rx_idle_on && $urandom_range(99) < 29) begin
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // empty tables straight after reset
  task automatic test_reset_state();
    send_req(CMD_QUERY_LOOP, 16'h0000, 16'h0000);
    send_req(CMD_QUERY_PARENT, 16'h1234, 16'h0000);
    send_req(CMD_BEGIN, 16'hFFFF, 16'hFFFF);
  endtask

  // nested headers, repeated header key
  task automatic test_headers();
    send_req(CMD_HEADER, 16'h0010, 16'h0000);
    send_req(CMD_HEADER, 16'h0020, 16'hFFFF);
    send_req(CMD_HEADER, 16'h0020, 16'h0000);
    send_req(CMD_QUERY_PARENT, 16'h0020, 16'h0000);
    send_req(CMD_QUERY_PARENT, 16'h0010, 16'h0000);
  endtask

  // forward, equal, backward, repeated origin, unknown target
  task automatic test_jumps();
    send_req(CMD_JUMP, 16'h0030, 16'h0040);
    send_req(CMD_JUMP, 16'h0035, 16'h0035);
    send_req(CMD_JUMP, 16'h0050, 16'h0020);
    send_req(CMD_JUMP, 16'h0050, 16'h0010);
    send_req(CMD_JUMP, 16'h0060, 16'h0055);
  endtask

  task automatic test_queries();
    send_req(CMD_QUERY_LOOP, 16'h0025, 16'h0000);
    send_req(CMD_QUERY_LOOP, 16'h0052, 16'h0000);
    send_req(CMD_QUERY_LOOP, 16'h0005, 16'h0000);
    send_req(CMD_QUERY_LOOP, 16'hFFFF, 16'h0000);
    send_req(CMD_QUERY_PARENT, 16'h0055, 16'h0000);
  endtask

  // codes 5 to 7 and the offset extremes
  task automatic test_unused_and_extremes();
    for (int c = CMD_BEGIN + 1; c < 8; c++) send_req(LTRK_CMD_W'(c), 16'hFFFF, 16'hFFFF);
    send_req(CMD_HEADER, 16'hFFFF, 16'h0000);
    send_req(CMD_JUMP, 16'hFFFF, 16'h0000);
    send_req(CMD_QUERY_LOOP, 16'h0000, 16'hFFFF);
    send_req(CMD_QUERY_PARENT, 16'hFFFF, 16'hFFFF);
    send_req(CMD_BEGIN, 16'h0000, 16'h0000);
  endtask

  // fill the header table, then the backedge table
  task automatic test_table_full();
    send_req(CMD_BEGIN, 16'h0000, 16'h0000);
    for (int i = 0; i < LTRK_MAX_LOOPS; i++) send_req(CMD_HEADER, 16'(i * 4 + 4), 16'h0000);
    send_req(CMD_HEADER, 16'h9000, 16'h0000);
    send_req(CMD_JUMP, 16'h9100, 16'h8000);
    send_req(CMD_JUMP, 16'h9100, 16'h0004);
    send_req(CMD_BEGIN, 16'h0000, 16'h0000);
    send_req(CMD_HEADER, 16'h0000, 16'h0000);
    for (int i = 1; i <= LTRK_MAX_LOOPS; i++) send_req(CMD_JUMP, 16'(i), 16'h0000);
    send_req(CMD_JUMP, 16'(LTRK_MAX_LOOPS + 1), 16'h0000);
    send_req(CMD_JUMP, 16'h0020, 16'h0000);
    send_req(CMD_QUERY_LOOP, 16'h001E, 16'h0000);
    send_req(CMD_BEGIN, 16'h0000, 16'h0000);
  endtask

  // receiver holds off long enough that the block stalls its input
  task automatic test_backpressure();
    rx_hold_left = 1500;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2) send_req(CMD_QUERY_LOOP, 16'(i * 8), 16'h0000);
      else send_req(CMD_HEADER, 16'(16'h0100 + i * 8), 16'h0000);
    end
    send_req(CMD_BEGIN, 16'h0000, 16'h0000);
  endtask

  // Random programs: nested loops built in offset order with queries, plus noise.
  task automatic test_random(int n_items);
    int                    sent;
    int                    prog_left;
    int                    r;
    logic [LTRK_OFS_W-1:0] pc;
    logic [LTRK_OFS_W-1:0] open_q[$];
    logic [LTRK_OFS_W-1:0] known_q[$];
    logic [LTRK_CMD_W-1:0] cmd;
    logic [LTRK_OFS_W-1:0] a;
    logic [LTRK_OFS_W-1:0] b;
    sent      = 0;
    prog_left = 0;
    pc        = '0;
    while (sent < n_items) begin
      // one long stretch with both sides busy
      tx_idle_on = !(sent >= n_items / 3 && sent < n_items / 3 + 150);
      rx_idle_on = tx_idle_on;
      a = LTRK_OFS_W'($urandom);
      b = LTRK_OFS_W'($urandom);
      if ($urandom_range(99) < 82) begin
        if (prog_left == 0 || pc > 16'hFF00) begin
          cmd       = CMD_BEGIN;
          pc        = LTRK_OFS_W'($urandom_range(0, 50000));
          prog_left = ($urandom_range(9) == 0) ? $urandom_range(100, 220) : $urandom_range(8, 60);
          open_q.delete();
          known_q.delete();
        end else begin
          r  = $urandom_range(99);
          prog_left--;
          pc = LTRK_OFS_W'(pc + $urandom_range(1, 40));
          if (r < 35 && open_q.size() < 10) begin
            cmd = CMD_HEADER;
            a   = pc;
            open_q.push_back(pc);
            known_q.push_back(pc);
          end else if (r < 65 && open_q.size() > 0) begin
            cmd = CMD_JUMP;
            a   = pc;
            b   = open_q.pop_back();
          end else if (r < 85) begin
            cmd = CMD_QUERY_LOOP;
            if (known_q.size() > 0 && $urandom_range(1))
              a = LTRK_OFS_W'(known_q[$urandom_range(known_q.size() - 1)] +
                              $urandom_range(0, 60));
            else
              a = LTRK_OFS_W'($urandom_range(0, pc + 100));
          end else begin
            cmd = CMD_QUERY_PARENT;
            if (known_q.size() > 0 && $urandom_range(3) != 0)
              a = known_q[$urandom_range(known_q.size() - 1)];
          end
        end
      end else begin
        case ($urandom_range(3))
          0: cmd = LTRK_CMD_W'($urandom_range(7));
          1: begin  // backward jump, most likely to an unknown header
            cmd = CMD_JUMP;
            if (a == 0) a = 16'h0001;
            b = LTRK_OFS_W'($urandom_range(0, a - 1));
          end
          2: begin  // header key seen before
            cmd = CMD_HEADER;
            if (known_q.size() > 0) a = known_q[$urandom_range(known_q.size() - 1)];
          end
          default: begin  // forward jump
            cmd = CMD_JUMP;
            b   = LTRK_OFS_W'($urandom_range(a, 16'hFFFF));
          end
        endcase
      end
      send_req(cmd, a, b);
      if (cmd <= CMD_BEGIN) sent++;
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_headers();
    test_jumps();
    test_queries();
    test_unused_and_extremes();
    test_table_full();
    test_backpressure();
    test_random(750);

    s_axis_tvalid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    // room for a stray extra result to show up
    repeat (LTRK_MAX_LOOPS + 16) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### loop_nesting_tracker_unit.f
sv/ltrk_pkg.sv
sv/ltrk_ctrl.sv
sv/ltrk_dpath.sv
sv/loop_nesting_tracker_unit.sv
test/tb_loop_nesting_tracker_unit.sv
